@@ hdl/dhcd_pkg.sv @@
// ----------------------------------------------------------------------------
// dhcd_pkg
// Shared types and constants of the detection head cell decoder.
// ----------------------------------------------------------------------------
package dhcd_pkg;

  // default sizing of the top level
  localparam int LANES_DEF       = 4;
  localparam int MAX_GRID_DEF    = 128;
  localparam int MAX_CLASSES_DEF = 1024;

  // stream payload widths
  localparam int IN_DATAW  = 64;
  localparam int OUT_DATAW = 176;
  localparam int IN_SCORES = 4;

  // configuration port
  localparam int CFG_IDXW  = 3;
  localparam int CFG_DATAW = 24;

  localparam logic [CFG_IDXW-1:0] REG_THRESHOLD_Q      = 3'd0;
  localparam logic [CFG_IDXW-1:0] REG_CLASS_ZERO_POINT = 3'd1;
  localparam logic [CFG_IDXW-1:0] REG_CLASS_SCALE      = 3'd2;
  localparam logic [CFG_IDXW-1:0] REG_BOX_ZERO_POINT   = 3'd3;
  localparam logic [CFG_IDXW-1:0] REG_BOX_SCALE        = 3'd4;
  localparam logic [CFG_IDXW-1:0] REG_CELL_STRIDE      = 3'd5;
  localparam logic [CFG_IDXW-1:0] REG_GRID_WIDTH       = 3'd6;
  localparam logic [CFG_IDXW-1:0] REG_ACTIVE_CLASSES   = 3'd7;

  // register reset values
  localparam logic [7:0]  THRESHOLD_Q_RST      = 8'd127;
  localparam logic [7:0]  CLASS_ZERO_POINT_RST = 8'd0;
  localparam logic [23:0] CLASS_SCALE_RST      = 24'd65536;
  localparam logic [7:0]  BOX_ZERO_POINT_RST   = 8'd0;
  localparam logic [23:0] BOX_SCALE_RST        = 24'd65536;
  localparam logic [15:0] CELL_STRIDE_RST      = 16'd2048;
  localparam logic [7:0]  GRID_WIDTH_RST       = 8'd80;
  localparam logic [10:0] ACTIVE_CLASSES_RST   = 11'd80;

  // result sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_FIN
  } dhcd_state_t;

  // per-step strobes from the sequencer to the datapath
  typedef struct packed {
    logic mul1;
    logic mul2;
    logic sum;
  } dhcd_step_t;

endpackage

@@ hdl/detection_head_cell_decode.sv @@
// ----------------------------------------------------------------------------
// detection_head_cell_decode
// Per-cell argmax and box decode for a quantized anchor-free detection head.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per group of four int8 class scores. in_tuser is
//           frame_start (clears cell position), in_tlast closes the cell and
//           then carries the four box distances.
//   out_* : one transaction per cell that has a class above threshold_q.
//   cfg_* : register writes, only while the block is idle.
// Throughput: one score group per cycle while the result sequencer is idle;
//   four lanes compare in parallel and merge into the running best at once.
// Result: a closing group with a winner starts the shared result sequencer
//   (two multiply steps, add, round/saturate). in_tready is low through its
//   MUL1, MUL2, SUM and FIN states, and the output register is loaded in FIN.
// Stall: the result sits in the output register; further groups are taken
//   meanwhile, and the next result waits in the sequencer's last step, with
//   in_tready low, until the output register is free.
// Reset: synchronous, clears position, class group, winner, the sequencer
//   and out_tvalid; registers return to their documented defaults.
// ----------------------------------------------------------------------------
module detection_head_cell_decode import dhcd_pkg::*; #(
  parameter int LANES       = LANES_DEF,
  parameter int MAX_GRID    = MAX_GRID_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: score_lane0, score_lane1, score_lane2, score_lane3,
  //           box_left, box_top, box_right, box_bottom (8 bits each)
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATAW-1:0]  in_tdata,
  input  logic                 in_tlast,
  // in_tuser: frame_start
  input  logic                 in_tuser,
  // out_tdata: obj_class(10), score(34), left_x(32), top_y(32),
  //            right_x(32), bottom_y(32), zero fill(4)
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DATAW-1:0] out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDXW-1:0]  cfg_addr,
  input  logic [CFG_DATAW-1:0] cfg_wdata
);

  localparam int NL  = (LANES < IN_SCORES) ? LANES : IN_SCORES;
  localparam int GBW = $clog2(MAX_CLASSES + 1);
  localparam int IDW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int PW  = $clog2(MAX_GRID);
  localparam int GCW = ((PW + 1) > 8) ? (PW + 1) : 8;

  // configuration
  logic signed [7:0] threshold_q_r;
  logic signed [7:0] class_zp_r;
  logic [23:0]       class_scale_r;
  logic signed [7:0] box_zp_r;
  logic [23:0]       box_scale_r;
  logic [15:0]       cell_stride_r;
  logic [7:0]        grid_width_r;
  logic [10:0]       active_classes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_q_r    <= THRESHOLD_Q_RST;
      class_zp_r       <= CLASS_ZERO_POINT_RST;
      class_scale_r    <= CLASS_SCALE_RST;
      box_zp_r         <= BOX_ZERO_POINT_RST;
      box_scale_r      <= BOX_SCALE_RST;
      cell_stride_r    <= CELL_STRIDE_RST;
      grid_width_r     <= GRID_WIDTH_RST;
      active_classes_r <= ACTIVE_CLASSES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD_Q:      threshold_q_r    <= cfg_wdata[7:0];
        REG_CLASS_ZERO_POINT: class_zp_r       <= cfg_wdata[7:0];
        REG_CLASS_SCALE:      class_scale_r    <= cfg_wdata[23:0];
        REG_BOX_ZERO_POINT:   box_zp_r         <= cfg_wdata[7:0];
        REG_BOX_SCALE:        box_scale_r      <= cfg_wdata[23:0];
        REG_CELL_STRIDE:      cell_stride_r    <= cfg_wdata[15:0];
        REG_GRID_WIDTH:       grid_width_r     <= cfg_wdata[7:0];
        REG_ACTIVE_CLASSES:   active_classes_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic signed [7:0] lane_score [NL];
  logic signed [7:0] box_q [4];
  logic              in_take;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_score[i] = in_tdata[8*i +: 8];
    end
    for (int j = 0; j < 4; j++) begin
      box_q[j] = in_tdata[32 + 8*j +: 8];
    end
  end

  assign in_take = in_tvalid & in_tready;

  // cell position and class group; frame_start clears them for this item
  logic [PW-1:0]  cell_col_r, cell_col_nxt, col_eff;
  logic [PW-1:0]  cell_row_r, cell_row_nxt, row_eff;
  logic [GBW-1:0] group_base_r, group_base_nxt, gb_eff;
  logic [GBW+3:0] gb_sum;
  logic [GCW-1:0] col_inc;

  assign col_eff = in_tuser ? '0 : cell_col_r;
  assign row_eff = in_tuser ? '0 : cell_row_r;
  assign gb_eff  = in_tuser ? '0 : group_base_r;
  assign gb_sum  = (GBW+4)'(gb_eff) + (GBW+4)'(LANES);
  assign col_inc = GCW'(col_eff) + GCW'(1);

  always_comb begin
    cell_col_nxt   = col_eff;
    cell_row_nxt   = row_eff;
    group_base_nxt = gb_eff;
    if (in_tlast) begin
      group_base_nxt = '0;
      if ((col_inc >= GCW'(grid_width_r)) || (col_inc >= GCW'(MAX_GRID))) begin
        cell_col_nxt = '0;
        cell_row_nxt = (row_eff == PW'(MAX_GRID - 1)) ? '0 : row_eff + PW'(1);
      end else begin
        cell_col_nxt = col_inc[PW-1:0];
      end
    end else if (gb_sum > (GBW+4)'(MAX_CLASSES)) begin
      group_base_nxt = GBW'(MAX_CLASSES);
    end else begin
      group_base_nxt = gb_sum[GBW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_col_r   <= '0;
      cell_row_r   <= '0;
      group_base_r <= '0;
    end else if (in_take) begin
      cell_col_r   <= cell_col_nxt;
      cell_row_r   <= cell_row_nxt;
      group_base_r <= group_base_nxt;
    end
  end

  // score lanes and merge
  logic [NL-1:0]     lane_hit;
  logic [IDW-1:0]    lane_cls [NL];
  logic              win;
  logic signed [7:0] win_score;
  logic [IDW-1:0]    win_class;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    dhcd_lane #(
      .MAX_CLASSES(MAX_CLASSES),
      .IDX        (g)
    ) u_lane (
      .base          (gb_eff),
      .active_classes(active_classes_r),
      .thr           (threshold_q_r),
      .score         (lane_score[g]),
      .hit           (lane_hit[g]),
      .cls_id        (lane_cls[g])
    );
  end

  dhcd_merge #(
    .LANES      (LANES),
    .MAX_CLASSES(MAX_CLASSES)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .clr      (in_tuser),
    .last     (in_tlast),
    .hit      (lane_hit),
    .score    (lane_score),
    .cls_id   (lane_cls),
    .win      (win),
    .win_score(win_score),
    .win_class(win_class)
  );

  // capture of a finished cell
  logic              start;
  logic [IDW-1:0]    cap_class_r;
  logic signed [7:0] cap_score_r;
  logic [PW-1:0]     cap_col_r;
  logic [PW-1:0]     cap_row_r;
  logic signed [7:0] cap_q_r [4];

  assign start = in_take & in_tlast & win;

  always_ff @(posedge clk) begin
    if (start) begin
      cap_class_r <= win_class;
      cap_score_r <= win_score;
      cap_col_r   <= col_eff;
      cap_row_r   <= row_eff;
      for (int j = 0; j < 4; j++) begin
        cap_q_r[j] <= box_q[j];
      end
    end
  end

  // result sequencer
  dhcd_state_t state_r, state_nxt;
  dhcd_step_t  step;
  logic        out_load;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step      = '0;
    out_load  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (start) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        step.mul1 = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        step.mul2 = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        step.sum  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // dequantized score
  logic signed [8:0]  sdq;
  logic signed [33:0] score_r;

  assign sdq = {cap_score_r[7], cap_score_r} - {class_zp_r[7], class_zp_r};

  always_ff @(posedge clk) begin
    if (step.mul1) begin
      score_r <= 34'(sdq) * 34'($signed({1'b0, class_scale_r}));
    end
  end

  // corners: left, top, right, bottom
  logic signed [31:0] corner_res [4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    dhcd_corner #(
      .MAX_GRID(MAX_GRID),
      .SUBTRACT(c < 2)
    ) u_corner (
      .clk      (clk),
      .step     (step),
      .pos      ((c % 2 == 0) ? cap_col_r : cap_row_r),
      .q        (cap_q_r[c]),
      .zp       (box_zp_r),
      .box_scale(box_scale_r),
      .stride   (cell_stride_r),
      .res      (corner_res[c])
    );
  end

  // output register
  logic [IDW+9:0]     cls_ext;
  logic [9:0]         out_class_r;
  logic signed [33:0] out_score_r;
  logic signed [31:0] out_corner_r [4];

  assign cls_ext = {10'b0, cap_class_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class_r <= cls_ext[9:0];
      out_score_r <= score_r;
      for (int j = 0; j < 4; j++) begin
        out_corner_r[j] <= corner_res[j];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_corner_r[3], out_corner_r[2], out_corner_r[1],
                       out_corner_r[0], out_score_r, out_class_r};

endmodule

@@ hdl/dhcd_lane.sv @@
// ----------------------------------------------------------------------------
// dhcd_lane
// One score lane: decides whether its class is in range and above threshold.
// ----------------------------------------------------------------------------
module dhcd_lane import dhcd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int IDX         = 0,
  localparam int GBW = $clog2(MAX_CLASSES + 1),
  localparam int IDW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic [GBW-1:0]   base,
  input  logic [10:0]      active_classes,
  input  logic signed [7:0] thr,
  input  logic signed [7:0] score,
  output logic             hit,
  output logic [IDW-1:0]   cls_id
);

  localparam int CLSW = ((GBW > 11) ? GBW : 11) + 4;

  logic [CLSW-1:0] cls;

  assign cls    = CLSW'(base) + CLSW'(IDX);
  assign hit    = (cls < CLSW'(active_classes)) && (cls < CLSW'(MAX_CLASSES))
                  && (score > thr);
  assign cls_id = cls[IDW-1:0];

endmodule

@@ hdl/dhcd_merge.sv @@
// ----------------------------------------------------------------------------
// dhcd_merge
// Merges the lane hits of one group into the running best of the cell.
// ----------------------------------------------------------------------------
module dhcd_merge import dhcd_pkg::*; #(
  parameter int LANES       = LANES_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  localparam int NL  = (LANES < IN_SCORES) ? LANES : IN_SCORES,
  localparam int IDW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic                clr,
  input  logic                last,
  input  logic [NL-1:0]       hit,
  input  logic signed [7:0]   score [NL],
  input  logic [IDW-1:0]      cls_id [NL],
  output logic                win,
  output logic signed [7:0]   win_score,
  output logic [IDW-1:0]      win_class
);

  logic                have_r;
  logic signed [7:0]   lead_score_r;
  logic [IDW-1:0]      lead_class_r;

  // lanes in ascending class order; strict compare keeps the first on a tie
  always_comb begin
    win       = ~clr & have_r;
    win_score = lead_score_r;
    win_class = lead_class_r;
    for (int i = 0; i < NL; i++) begin
      if (hit[i] && (!win || (score[i] > win_score))) begin
        win       = 1'b1;
        win_score = score[i];
        win_class = cls_id[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= last ? 1'b0 : win;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lead_score_r <= win_score;
      lead_class_r <= win_class;
    end
  end

endmodule

@@ hdl/dhcd_corner.sv @@
// ----------------------------------------------------------------------------
// dhcd_corner
// One box corner: center of the cell minus or plus the scaled distance,
// truncated toward zero to 1/256 pixel and saturated to 32 bits.
// ----------------------------------------------------------------------------
module dhcd_corner import dhcd_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEF,
  parameter bit SUBTRACT = 1'b0,
  localparam int PW = $clog2(MAX_GRID)
) (
  input  logic               clk,
  input  dhcd_step_t         step,
  input  logic [PW-1:0]      pos,
  input  logic signed [7:0]  q,
  input  logic signed [7:0]  zp,
  input  logic [23:0]        box_scale,
  input  logic [15:0]        stride,
  output logic signed [31:0] res
);

  localparam int SW = ((PW + 34) > 52) ? (PW + 34) : 52;
  localparam int QW = SW - 16;
  localparam logic signed [QW-1:0] QMAX = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] QMIN = QW'(-64'sd2147483648);

  logic signed [8:0]    dq;
  logic signed [33:0]   prod1_r;
  logic [PW+16:0]       ctr_r;
  logic signed [50:0]   dist_r;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] cext;
  logic signed [SW-1:0] dext;
  logic signed [SW-1:0] biased;
  logic signed [QW-1:0] quo;

  assign dq   = {q[7], q} - {zp[7], zp};
  assign cext = $signed(SW'({ctr_r, 15'b0}));
  assign dext = SW'(dist_r);

  always_ff @(posedge clk) begin
    if (step.mul1) begin
      prod1_r <= 34'(dq) * 34'($signed({1'b0, box_scale}));
      ctr_r   <= (PW+17)'({pos, 1'b1}) * (PW+17)'(stride);
    end
    if (step.mul2) begin
      dist_r <= 51'(prod1_r) * 51'($signed({1'b0, stride}));
    end
    if (step.sum) begin
      sum_r <= SUBTRACT ? (cext - dext) : (cext + dext);
    end
  end

  // divide by 2^16 toward zero: bias negative values before the shift
  always_comb begin
    biased = sum_r + (sum_r[SW-1] ? SW'(65535) : SW'(0));
    quo    = biased[SW-1:16];
    if (quo > QMAX) begin
      res = 32'sh7FFFFFFF;
    end else if (quo < QMIN) begin
      res = 32'sh80000000;
    end else begin
      res = quo[31:0];
    end
  end

endmodule
